### rtl/bci_pkg.sv
// Shared types and constants of the breakpoint curve interpolator.
// Item structs, command and status codes, and controller/datapath bundles.
package bci_pkg;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] position;
		logic signed [31:0] point_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] curve_value;
		logic               in_range;
		logic [1:0]         status;
	} out_item_t;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int         DIV_STEPS = 64;
	localparam int         DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
	localparam logic [33:0] SAT_MAG = 34'h2_0000_0000;

	typedef enum logic [1:0] {
		RA_ZERO,
		RA_LAST,
		RA_ONE,
		RA_NEXT
	} rd_sel_t;

	typedef enum logic [3:0] {
		RS_NONE,
		RS_ZERO,
		RS_FULL,
		RS_EMPTY,
		RS_LO_OUT,
		RS_RD_OUT,
		RS_LO_IN,
		RS_HI_IN,
		RS_LERP
	} res_sel_t;

	typedef struct packed {
		logic     latch_in;
		logic     clear_count;
		logic     append;
		rd_sel_t  rd_sel;
		logic     load_lo;
		logic     load_hi;
		logic     idx_init;
		logic     idx_inc;
		logic     diff_load;
		logic     mul_load;
		logic     div_step;
		logic     sign_load;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       count_zero;
		logic       count_full;
		logic       count_one;
		logic       q_below;
		logic       q_above;
		logic       search_go;
		logic       mode;
		logic       dp_zero;
		logic       div_last;
		logic       out_busy;
	} dp_status_t;

endpackage

### rtl/breakpoint_curve_interpolator_core.sv
// Top level of the breakpoint curve interpolator.
// Joins bci_ctrl and bci_dpath; types come from bci_pkg.
//
// Usage: a table of up to MAX_POINTS (position, value) breakpoints in signed
// Q16.16, loaded by clear and append items and read back by query items.
// Input channel in_valid/in_ready/in_data carries one item: command,
// position, point_value. Output channel out_valid/out_ready/out_data returns
// exactly one item per input item: curve_value, in_range, status.
// cfg_we/cfg_wdata set interp_mode (0 linear, 1 step); write it only while idle.
// Path to the result: clear, append, the unused command and an empty-table
// query are decoded straight to it; an out-of-range or single-point query
// also reads the first and last breakpoints; a linear query inside the table
// scans for the upper breakpoint (one memory read per scan step), then runs
// 64 divider steps; step mode or a zero-width span ends after the scan.
// One item is worked on at a time; the next is accepted once the result has
// moved into the output register, so a new item may enter while the previous
// result still waits for out_ready.
// Reset (arst_n low) empties the table, sets linear mode and drops any
// pending result. A stalled receiver holds the result; the block then waits
// with its next result finished until the output register is free.
module breakpoint_curve_interpolator_core #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bci_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bci_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	bci_pkg::ctrl_cmd_t  cmd;
	bci_pkg::dp_status_t sts;

	// sequencer: decode, table scan, divide, emit
	bci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, arithmetic and output register
	bci_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### rtl/bci_ctrl.sv
// Controller state machine of the breakpoint curve interpolator.
// Depends on bci_pkg for the command and status bundles.
module bci_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bci_pkg::dp_status_t   sts,
	output bci_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DECODE = 11'b000_0000_0010,
		S_FIRST  = 11'b000_0000_0100,
		S_LAST   = 11'b000_0000_1000,
		S_SEARCH = 11'b000_0001_0000,
		S_DIFF   = 11'b000_0010_0000,
		S_MUL    = 11'b000_0100_0000,
		S_DIV    = 11'b000_1000_0000,
		S_SIGN   = 11'b001_0000_0000,
		S_SUM    = 11'b010_0000_0000,
		S_EMIT   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd_sel = bci_pkg::RA_ZERO;
		cmd.res_sel = bci_pkg::RS_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.command)
					bci_pkg::CMD_CLEAR: begin
						cmd.clear_count = 1'b1;
						cmd.res_sel = bci_pkg::RS_ZERO;
						state_d = S_EMIT;
					end
					bci_pkg::CMD_APPEND: begin
						if (sts.count_full) begin
							cmd.res_sel = bci_pkg::RS_FULL;
						end else begin
							cmd.append = 1'b1;
							cmd.res_sel = bci_pkg::RS_ZERO;
						end
						state_d = S_EMIT;
					end
					bci_pkg::CMD_QUERY: begin
						if (sts.count_zero) begin
							cmd.res_sel = bci_pkg::RS_EMPTY;
							state_d = S_EMIT;
						end else begin
							cmd.rd_sel = bci_pkg::RA_ZERO;
							state_d = S_FIRST;
						end
					end
					default: begin
						cmd.res_sel = bci_pkg::RS_ZERO;
						state_d = S_EMIT;
					end
				endcase
			end
			S_FIRST: begin
				cmd.load_lo = 1'b1;
				cmd.rd_sel = bci_pkg::RA_LAST;
				state_d = S_LAST;
			end
			S_LAST: begin
				if (sts.q_below) begin
					cmd.res_sel = bci_pkg::RS_LO_OUT;
					state_d = S_EMIT;
				end else if (sts.q_above) begin
					cmd.res_sel = bci_pkg::RS_RD_OUT;
					state_d = S_EMIT;
				end else if (sts.count_one) begin
					cmd.res_sel = bci_pkg::RS_LO_IN;
					state_d = S_EMIT;
				end else begin
					cmd.idx_init = 1'b1;
					cmd.rd_sel = bci_pkg::RA_ONE;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.search_go) begin
					cmd.load_lo = 1'b1;
					cmd.idx_inc = 1'b1;
					cmd.rd_sel = bci_pkg::RA_NEXT;
				end else begin
					cmd.load_hi = 1'b1;
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				if (sts.mode || sts.dp_zero) begin
					cmd.res_sel = bci_pkg::RS_HI_IN;
					state_d = S_EMIT;
				end else begin
					cmd.diff_load = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SIGN;
				end
			end
			S_SIGN: begin
				cmd.sign_load = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.res_sel = bci_pkg::RS_LERP;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/bci_dpath.sv
// Datapath of the breakpoint curve interpolator: breakpoint memories,
// search registers, multiply/divide unit and output register. Uses bci_pkg.
module bci_dpath #(
	parameter int MAX_POINTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bci_pkg::ctrl_cmd_t    cmd,
	output bci_pkg::dp_status_t   sts,
	input  bci_pkg::in_item_t     in_data,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bci_pkg::out_item_t    out_data
);

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic signed [31:0] pos_mem [MAX_POINTS];
	logic signed [31:0] val_mem [MAX_POINTS];

	bci_pkg::in_item_t  in_q;
	logic               mode_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [31:0] rd_pos_q, rd_val_q;
	logic signed [31:0] p_lo_q, v_lo_q, p_hi_q, v_hi_q;
	logic [31:0]        dv_mag_q, dq_mag_q, dp_mag_q;
	logic               neg_q;
	logic [63:0]        quo_q;
	logic [31:0]        rem_q;
	logic [bci_pkg::DIV_CNT_W-1:0] step_q;
	logic signed [34:0] lerp_q;
	bci_pkg::out_item_t res_q, out_q;
	logic               out_valid_q;

	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;

	function automatic logic [31:0] mag33(input logic [32:0] x);
		logic [32:0] n;
		n = ~x + 33'd1;
		return x[32] ? n[31:0] : x[31:0];
	endfunction

	assign cnt_m1  = count_q - CNT_W'(1);
	assign wr_addr = count_q[IDX_W-1:0];

	always_comb begin
		case (cmd.rd_sel)
			bci_pkg::RA_ZERO: rd_addr = '0;
			bci_pkg::RA_LAST: rd_addr = cnt_m1[IDX_W-1:0];
			bci_pkg::RA_ONE:  rd_addr = IDX_W'(1);
			bci_pkg::RA_NEXT: rd_addr = idx_q + IDX_W'(1);
			default:          rd_addr = '0;
		endcase
	end

	// breakpoint memories
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			pos_mem[wr_addr] <= in_q.position;
			val_mem[wr_addr] <= in_q.point_value;
		end
		rd_pos_q <= pos_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.mul_load) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + bci_pkg::DIV_CNT_W'(1);
			end
		end
	end

	// divider step: shift in one dividend bit, subtract when it fits
	logic [32:0] rem_sh, rem_sub;
	logic        rem_ge;
	assign rem_sh  = {rem_q, quo_q[63]};
	assign rem_ge  = rem_sh >= {1'b0, dp_mag_q};
	assign rem_sub = rem_sh - {1'b0, dp_mag_q};

	logic [32:0] dv_w, dq_w, dp_w;
	assign dv_w = {v_hi_q[31], v_hi_q} - {v_lo_q[31], v_lo_q};
	assign dq_w = {in_q.position[31], in_q.position} - {p_lo_q[31], p_lo_q};
	assign dp_w = {p_hi_q[31], p_hi_q} - {p_lo_q[31], p_lo_q};

	logic [33:0]        m_sat;
	logic [34:0]        mag35;
	logic signed [35:0] sum36;
	logic signed [31:0] lerp_res;
	assign m_sat = (quo_q > {30'd0, bci_pkg::SAT_MAG}) ? bci_pkg::SAT_MAG : quo_q[33:0];
	assign mag35 = {1'b0, m_sat};
	assign sum36 = $signed({{4{v_lo_q[31]}}, v_lo_q}) + $signed({lerp_q[34], lerp_q});

	always_comb begin
		if (sum36 > 36'sd2147483647) begin
			lerp_res = 32'sh7FFF_FFFF;
		end else if (sum36 < -36'sd2147483648) begin
			lerp_res = 32'sh8000_0000;
		end else begin
			lerp_res = sum36[31:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_q <= in_data;
		end
		if (cmd.idx_init) begin
			idx_q <= IDX_W'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.load_lo) begin
			p_lo_q <= rd_pos_q;
			v_lo_q <= rd_val_q;
		end
		if (cmd.load_hi) begin
			p_hi_q <= rd_pos_q;
			v_hi_q <= rd_val_q;
		end
		if (cmd.diff_load) begin
			dv_mag_q <= mag33(dv_w);
			dq_mag_q <= mag33(dq_w);
			dp_mag_q <= mag33(dp_w);
			neg_q    <= dv_w[32] ^ dq_w[32] ^ dp_w[32];
		end
		if (cmd.mul_load) begin
			quo_q <= dv_mag_q * dq_mag_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[62:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
		end
		if (cmd.sign_load) begin
			lerp_q <= neg_q ? $signed(~mag35 + 35'd1) : $signed(mag35);
		end
		case (cmd.res_sel)
			bci_pkg::RS_NONE: ;
			bci_pkg::RS_ZERO:   res_q <= '{32'sd0, 1'b0, bci_pkg::ST_OK};
			bci_pkg::RS_FULL:   res_q <= '{32'sd0, 1'b0, bci_pkg::ST_FULL};
			bci_pkg::RS_EMPTY:  res_q <= '{32'sd0, 1'b0, bci_pkg::ST_EMPTY};
			bci_pkg::RS_LO_OUT: res_q <= '{v_lo_q, 1'b0, bci_pkg::ST_OK};
			bci_pkg::RS_RD_OUT: res_q <= '{rd_val_q, 1'b0, bci_pkg::ST_OK};
			bci_pkg::RS_LO_IN:  res_q <= '{v_lo_q, 1'b1, bci_pkg::ST_OK};
			bci_pkg::RS_HI_IN:  res_q <= '{v_hi_q, 1'b1, bci_pkg::ST_OK};
			bci_pkg::RS_LERP:   res_q <= '{lerp_res, 1'b1, bci_pkg::ST_OK};
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign sts.command    = in_q.command;
	assign sts.count_zero = (count_q == '0);
	assign sts.count_full = (count_q == CNT_W'(MAX_POINTS));
	assign sts.count_one  = (count_q == CNT_W'(1));
	assign sts.q_below    = in_q.position < p_lo_q;
	assign sts.q_above    = in_q.position > rd_pos_q;
	assign sts.search_go  = (CNT_W'(idx_q) < cnt_m1) && (in_q.position > rd_pos_q);
	assign sts.mode       = mode_q;
	assign sts.dp_zero    = (p_hi_q == p_lo_q);
	assign sts.div_last   = (step_q == bci_pkg::DIV_LAST);
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/bci_chk.sv
// Port-level checker for the breakpoint curve interpolator, bound to the top.
// Uses bci_pkg for item types and status codes.
module bci_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bci_pkg::out_item_t out_data
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second item taken while one is at work");

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two items outstanding");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without an accepted item");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != bci_pkg::ST_OK
		|-> !out_data.in_range && out_data.curve_value == 32'sd0)
		else $error("error result carries a value");

endmodule

bind breakpoint_curve_interpolator_core bci_chk u_bci_chk (.*);
